// ----- rtl/lidar_frame_parser_assert.svh -----
// Assertion macros shared by the lidar frame parser RTL.
// Included by the top level; depends on nothing else.
`ifndef LIDAR_FRAME_PARSER_ASSERT_SVH
`define LIDAR_FRAME_PARSER_ASSERT_SVH

`define LFP_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("lfp assertion failed");

`define LFP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfp assertion failed");

`define LFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfp assertion failed");

`endif

// ----- rtl/lfp_pkg.sv -----
// Package for the lidar frame parser: constants, command and status types.
// Used by every module of the block; depends on nothing.
package lfp_pkg;

  localparam logic [7:0]  StartByte      = 8'h59;
  localparam logic [15:0] InvalidDistRst = 16'd45000;
  localparam int unsigned FrameLen       = 9;
  localparam int unsigned PosW           = 4;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAddrW = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    CMD_START,
    CMD_HDR,
    CMD_DLO,
    CMD_DHI,
    CMD_SLO,
    CMD_SHI,
    CMD_ADD,
    CMD_CHECK
  } cmd_kind_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_HDR = 2'd1,
    STAT_BAD_SUM = 2'd2,
    STAT_INVALID = 2'd3
  } frame_status_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ----- rtl/lfp_front.sv -----
// Front end of the lidar frame parser: tracks the frame position and tags bytes.
// Depends on lfp_pkg; feeds lfp_queue.
module lfp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rx_valid_i,
  output logic              rx_stall_o,
  input  logic [7:0]        rx_byte_i,
  input  lfp_pkg::qstat_t   qstat_i,
  output logic              push_o,
  output lfp_pkg::cmd_t     cmd_o
);

  logic [lfp_pkg::PosW-1:0] pos_q, pos_d;
  logic                     accept;
  logic                     hunting;

  assign rx_stall_o = qstat_i.full;
  assign accept     = rx_valid_i && !qstat_i.full;
  assign hunting    = (pos_q == '0) || (pos_q >= lfp_pkg::PosW'(lfp_pkg::FrameLen));

  always_comb begin
    pos_d       = pos_q;
    push_o      = 1'b0;
    cmd_o.data  = rx_byte_i;
    cmd_o.kind  = lfp_pkg::CMD_ADD;
    if (accept) begin
      if (hunting) begin
        if (rx_byte_i == lfp_pkg::StartByte) begin
          push_o     = 1'b1;
          cmd_o.kind = lfp_pkg::CMD_START;
          pos_d      = lfp_pkg::PosW'(1);
        end else begin
          pos_d = '0;
        end
      end else begin
        push_o = 1'b1;
        pos_d  = pos_q + 1'b1;
        unique case (pos_q)
          lfp_pkg::PosW'(1): cmd_o.kind = lfp_pkg::CMD_HDR;
          lfp_pkg::PosW'(2): cmd_o.kind = lfp_pkg::CMD_DLO;
          lfp_pkg::PosW'(3): cmd_o.kind = lfp_pkg::CMD_DHI;
          lfp_pkg::PosW'(4): cmd_o.kind = lfp_pkg::CMD_SLO;
          lfp_pkg::PosW'(5): cmd_o.kind = lfp_pkg::CMD_SHI;
          lfp_pkg::PosW'(8): begin
            cmd_o.kind = lfp_pkg::CMD_CHECK;
            pos_d      = '0;
          end
          default: cmd_o.kind = lfp_pkg::CMD_ADD;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ----- rtl/lfp_queue.sv -----
// Short command queue between the front and back ends of the frame parser.
// Depends on lfp_pkg for its depth and entry type.
module lfp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lfp_pkg::cmd_t    cmd_i,
  input  logic             pop_i,
  output lfp_pkg::cmd_t    head_o,
  output lfp_pkg::qstat_t  qstat_o
);

  lfp_pkg::cmd_t              mem_q [lfp_pkg::QDepth];
  logic [lfp_pkg::QAddrW-1:0] wr_q, rd_q;
  logic [lfp_pkg::QCntW-1:0]  cnt_q;
  logic                       do_push, do_pop;

  assign qstat_o.full  = (cnt_q == lfp_pkg::QCntW'(lfp_pkg::QDepth));
  assign qstat_o.empty = (cnt_q == '0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign head_o        = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == lfp_pkg::QAddrW'(lfp_pkg::QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == lfp_pkg::QAddrW'(lfp_pkg::QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- rtl/lfp_back.sv -----
// Back end of the frame parser: accumulates checksum and fields, grades the frame.
// Depends on lfp_pkg; drains lfp_queue and holds the result register.
module lfp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lfp_pkg::cmd_t    head_i,
  input  lfp_pkg::qstat_t  qstat_i,
  output logic             pop_o,
  input  logic [15:0]      invalid_code_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [15:0]      distance_o,
  output logic [15:0]      strength_o,
  output logic [1:0]       frame_status_o
);

  logic [7:0]  sum_q, sum_d;
  logic [7:0]  hdr_q;
  logic [15:0] dist_q, str_q;
  logic        out_valid_q;
  logic [15:0] out_dist_q, out_str_q;
  logic [1:0]  out_stat_q;
  logic        out_free;
  logic        is_check;
  lfp_pkg::frame_status_e stat;

  assign out_free = !out_valid_q || !out_stall_i;
  assign is_check = (head_i.kind == lfp_pkg::CMD_CHECK);
  assign pop_o    = !qstat_i.empty && (!is_check || out_free);
  assign sum_d    = sum_q + head_i.data;

  always_comb begin
    priority if (hdr_q != lfp_pkg::StartByte) begin
      stat = lfp_pkg::STAT_BAD_HDR;
    end else if (head_i.data != sum_q) begin
      stat = lfp_pkg::STAT_BAD_SUM;
    end else if (dist_q == invalid_code_i) begin
      stat = lfp_pkg::STAT_INVALID;
    end else begin
      stat = lfp_pkg::STAT_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      unique case (head_i.kind)
        lfp_pkg::CMD_HDR: hdr_q        <= head_i.data;
        lfp_pkg::CMD_DLO: dist_q[7:0]  <= head_i.data;
        lfp_pkg::CMD_DHI: dist_q[15:8] <= head_i.data;
        lfp_pkg::CMD_SLO: str_q[7:0]   <= head_i.data;
        lfp_pkg::CMD_SHI: str_q[15:8]  <= head_i.data;
        lfp_pkg::CMD_CHECK: begin
          out_dist_q <= dist_q;
          out_str_q  <= str_q;
          out_stat_q <= stat;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o && is_check) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        unique case (head_i.kind)
          lfp_pkg::CMD_START: sum_q <= head_i.data;
          lfp_pkg::CMD_CHECK: sum_q <= '0;
          default:            sum_q <= sum_d;
        endcase
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign distance_o     = out_dist_q;
  assign strength_o     = out_str_q;
  assign frame_status_o = out_stat_q;

endmodule

// ----- rtl/lidar_frame_parser.sv -----
// Lidar frame parser: takes serial bytes and returns one graded result per 9-byte frame.
// The rx channel accepts a byte when rx_valid_i is high and rx_stall_o is low; the
// out channel hands over a result when out_valid_o is high and out_stall_i is low.
// While hunting, bytes other than 0x59 are taken and dropped. A 0x59 opens a frame;
// after the ninth byte one word is delivered with the distance, the strength and
// a status (ok, bad second header, checksum mismatch, invalid distance).
// The front end tags each byte by its frame position and pushes it into a
// four-entry queue; the back end drains one entry per cycle into the checksum,
// field and result registers, except that a final byte waits while a result is stalled.
// Throughput is one byte per cycle while rx_stall_o is low. The final byte of a frame
// is registered in the queue, then its result in the result register once that is free.
// While out_stall_i holds a result, the back end keeps draining non-final bytes;
// the next frame's final byte waits in the queue, and once the queue fills,
// rx_stall_o rises. Reset clears the frame position, checksum, queue and result
// valid, and loads the invalid-distance register with 45000. cfg_we_i writes
// cfg_wdata_i into that register and should only be used while the block is idle.
// Depends on lfp_pkg, lfp_front, lfp_queue, lfp_back and the assertion header.
`include "lidar_frame_parser_assert.svh"

module lidar_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] distance_o,
  output logic [15:0] strength_o,
  output logic [1:0]  frame_status_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [15:0]     invalid_code_q;
  logic            push;
  logic            pop;
  lfp_pkg::cmd_t   push_cmd;
  lfp_pkg::cmd_t   head;
  lfp_pkg::qstat_t qstat;
  logic            head_check;
  logic            pop_check;

  assign head_check = (head.kind == lfp_pkg::CMD_CHECK);
  assign pop_check  = pop && head_check;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invalid_code_q <= lfp_pkg::InvalidDistRst;
    end else if (cfg_we_i) begin
      invalid_code_q <= cfg_wdata_i;
    end
  end

  lfp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_stall_o (rx_stall_o),
    .rx_byte_i  (rx_byte_i),
    .qstat_i    (qstat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  lfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  lfp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .qstat_i        (qstat),
    .pop_o          (pop),
    .invalid_code_i (invalid_code_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .distance_o     (distance_o),
    .strength_o     (strength_o),
    .frame_status_o (frame_status_o)
  );

  `LFP_ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, pop && qstat.empty)
  `LFP_ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, push && qstat.full)
  `LFP_ASSERT_NEXT(a_check_gives_result, clk_i, rst_ni, pop_check, out_valid_o)
  `LFP_ASSERT_IMPLIES(a_check_waits_for_slot, clk_i, rst_ni, out_valid_o && out_stall_i && head_check, !pop)

endmodule
